// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port-level checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define AVBA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define AVBA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/avba_pkg.sv =====
// shared types, codes and default sizes of the vector block allocator
// no dependencies
package avba_pkg;

  // default sizes for the top level parameters
  localparam int DEF_VECTORS      = 256;
  localparam int DEF_CPUS         = 16;
  localparam int DEF_LEGACY_LINES = 16;

  // fixed vector numbers and field constants
  localparam int unsigned CASCADE_LINE = 2;
  localparam int unsigned SYSCALL_SLOT = 96;
  localparam logic [8:0]  BASE_NONE    = 9'h100;
  localparam logic [5:0]  MAX_BLOCK    = 6'd32;
  localparam logic [7:0]  START_MASK   = 8'hE0;

  typedef enum logic [2:0] {
    KIND_UNUSED   = 3'd0,
    KIND_RESERVED = 3'd1,
    KIND_LEGACY   = 3'd2,
    KIND_SYSCALL  = 3'd3,
    KIND_MSI      = 3'd4,
    KIND_MSIX     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_BADREQ  = 3'd2,
    ST_KIND    = 3'd3,
    ST_BASE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FN_ALLOC_MSI  = 3'd0,
    FN_ALLOC_MSIX = 3'd1,
    FN_REL_MSI    = 3'd2,
    FN_REL_MSIX   = 3'd3,
    FN_MAP        = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_BOUND,
    S_A_RD,
    S_A_CHK,
    S_A_WR,
    S_R_BOUND,
    S_R_RD,
    S_R_CHK,
    S_R_WR,
    S_M_RD,
    S_M_CHK,
    S_DONE
  } state_t;

  // one table entry: kind and block base (bit 8 set means none)
  typedef struct packed {
    kind_t      kind;
    logic [8:0] base;
  } entry_t;

endpackage

// ===== hw/rtl/avba_if.sv =====
// valid/ready channel interfaces: request, response and config write
// depends on nothing
interface avba_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] cpu;
  logic [7:0] vector;
  logic [5:0] count;
  modport source (output valid, func, cpu, vector, count, input ready);
  modport sink (input valid, func, cpu, vector, count, output ready);
endinterface

interface avba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] base_vector;
  modport source (output valid, status, base_vector, input ready);
  modport sink (input valid, status, base_vector, output ready);
endinterface

interface avba_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/aligned_vector_block_allocator_top.sv =====
// Per request: map reads and checks one entry; a rejected request goes to the result;
// release reads the block's entries (plus the entry past the block inside the table),
// then clears count entries; alloc reads each candidate block up to its first used
// entry, then writes count entries. One request at a time: a new beat waits for the
// result. Reset: synchronous; a pass clearing all 2**(CPU_W + clog2(VECTORS)) entries
// (4096 at defaults) runs before requests; depends on avba_pkg, avba_if, avba_table.
module aligned_vector_block_allocator_top #(
  parameter int VECTORS      = avba_pkg::DEF_VECTORS,
  parameter int CPUS         = avba_pkg::DEF_CPUS,
  parameter int LEGACY_LINES = avba_pkg::DEF_LEGACY_LINES
) (
  input logic      clk,
  input logic      rst,
  avba_req_if.sink   req,
  avba_rsp_if.source rsp,
  avba_cfg_if.sink   cfg
);

  localparam int VEC_W  = $clog2(VECTORS);
  localparam int CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int ADDR_W = CPU_W + VEC_W;

  avba_pkg::state_t  state, state_next;
  avba_pkg::kind_t   op_kind;
  avba_pkg::status_t res_status;
  logic [7:0]        res_base;
  logic [CPU_W-1:0]  cpu_idx;
  logic [8:0]        base;
  logic [5:0]        off;
  logic [5:0]        n;
  logic              base_bad;
  logic              have_next;
  logic [7:0]        search_start;

  logic              out_valid;
  logic [2:0]        out_status;
  logic [7:0]        out_base;

  logic              busy;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  avba_pkg::entry_t  mem_wdata;
  avba_pkg::entry_t  rdata;

  logic [CPU_W+3:0]  cpu_wide;
  logic              req_fire;
  logic              out_load;
  logic              cnt_ok;
  avba_pkg::state_t  acc_state;
  avba_pkg::kind_t   acc_kind;
  logic [5:0]        acc_n;
  logic [8:0]        acc_base;
  logic [5:0]        opnd;
  logic [8:0]        sum;
  logic [5:0]        off_inc;
  logic              last;
  logic              over;
  logic              misalign;
  logic              kind_match;
  logic              bb;
  logic              extra_match;

  avba_table #(
    .VECTORS      (VECTORS),
    .CPUS         (CPUS),
    .LEGACY_LINES (LEGACY_LINES)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .busy  (busy),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (rdata)
  );

  // config register, low five bits forced to zero
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= '0;
    end else if (cfg.valid) begin
      search_start <= cfg.data & avba_pkg::START_MASK;
    end
  end

  // request decode
  assign req_fire = req.valid && req.ready;
  assign cpu_wide = {{CPU_W{1'b0}}, req.cpu};
  assign cnt_ok   = (req.count != 6'd0) && (req.count <= avba_pkg::MAX_BLOCK) &&
                    ((req.count & (req.count - 6'd1)) == 6'd0);

  always_comb begin
    acc_state = avba_pkg::S_DONE;
    acc_kind  = avba_pkg::KIND_MSI;
    acc_n     = req.count;
    acc_base  = {1'b0, req.vector};
    case (req.func)
      avba_pkg::FN_ALLOC_MSI: begin
        acc_base = {1'b0, search_start};
        if (cnt_ok) acc_state = avba_pkg::S_A_BOUND;
      end
      avba_pkg::FN_ALLOC_MSIX: begin
        acc_base  = {1'b0, search_start};
        acc_kind  = avba_pkg::KIND_MSIX;
        acc_n     = 6'd1;
        acc_state = avba_pkg::S_A_BOUND;
      end
      avba_pkg::FN_REL_MSI: begin
        if (cnt_ok) acc_state = avba_pkg::S_R_BOUND;
      end
      avba_pkg::FN_REL_MSIX: begin
        acc_kind  = avba_pkg::KIND_MSIX;
        acc_n     = 6'd1;
        acc_state = avba_pkg::S_R_BOUND;
      end
      avba_pkg::FN_MAP: begin
        if (32'(req.vector) < VECTORS) acc_state = avba_pkg::S_M_RD;
      end
      default: acc_state = avba_pkg::S_DONE;
    endcase
    if (!(32'(req.cpu) < CPUS)) acc_state = avba_pkg::S_DONE;
  end

  // shared address adder: block base plus offset or block size
  always_comb begin
    case (state)
      avba_pkg::S_A_BOUND,
      avba_pkg::S_A_CHK,
      avba_pkg::S_R_BOUND: opnd = n;
      default:             opnd = off;
    endcase
  end
  assign sum      = base + {3'b000, opnd};
  assign off_inc  = off + 6'd1;
  assign last     = (off_inc == n);
  assign over     = 32'(sum) > VECTORS;
  assign misalign = (base[5:0] & (n - 6'd1)) != 6'd0;
  assign mem_addr = {cpu_idx, sum[VEC_W-1:0]};

  // entry checks for release
  assign kind_match  = (rdata.kind == op_kind);
  assign bb          = base_bad || (rdata.base != base);
  assign extra_match = kind_match && (rdata.base == base);
  assign out_load    = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      avba_pkg::S_IDLE:    if (req_fire) state_next = acc_state;
      avba_pkg::S_A_BOUND: state_next = over ? avba_pkg::S_DONE : avba_pkg::S_A_RD;
      avba_pkg::S_A_RD:    state_next = avba_pkg::S_A_CHK;
      avba_pkg::S_A_CHK: begin
        if (rdata.kind != avba_pkg::KIND_UNUSED) state_next = avba_pkg::S_A_BOUND;
        else if (last)                           state_next = avba_pkg::S_A_WR;
        else                                     state_next = avba_pkg::S_A_RD;
      end
      avba_pkg::S_A_WR:    if (last) state_next = avba_pkg::S_DONE;
      avba_pkg::S_R_BOUND: begin
        state_next = (over || misalign) ? avba_pkg::S_DONE : avba_pkg::S_R_RD;
      end
      avba_pkg::S_R_RD:    state_next = avba_pkg::S_R_CHK;
      avba_pkg::S_R_CHK: begin
        if (off == n) begin
          state_next = extra_match ? avba_pkg::S_DONE : avba_pkg::S_R_WR;
        end else if (!kind_match) begin
          state_next = avba_pkg::S_DONE;
        end else if (last) begin
          if (bb)             state_next = avba_pkg::S_DONE;
          else if (have_next) state_next = avba_pkg::S_R_RD;
          else                state_next = avba_pkg::S_R_WR;
        end else begin
          state_next = avba_pkg::S_R_RD;
        end
      end
      avba_pkg::S_R_WR:    if (last) state_next = avba_pkg::S_DONE;
      avba_pkg::S_M_RD:    state_next = avba_pkg::S_M_CHK;
      avba_pkg::S_M_CHK:   state_next = avba_pkg::S_DONE;
      avba_pkg::S_DONE:    if (out_load) state_next = avba_pkg::S_IDLE;
      default:             state_next = avba_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = (state == avba_pkg::S_IDLE) && !busy;
    mem_we    = (state == avba_pkg::S_A_WR) || (state == avba_pkg::S_R_WR);
    if (state == avba_pkg::S_A_WR) begin
      mem_wdata.kind = op_kind;
      mem_wdata.base = base;
    end else begin
      mem_wdata.kind = avba_pkg::KIND_UNUSED;
      mem_wdata.base = avba_pkg::BASE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      avba_pkg::S_IDLE: begin
        if (req_fire) begin
          base       <= acc_base;
          n          <= acc_n;
          op_kind    <= acc_kind;
          cpu_idx    <= cpu_wide[CPU_W-1:0];
          off        <= 6'd0;
          base_bad   <= 1'b0;
          res_status <= avba_pkg::ST_BADREQ;
          res_base   <= 8'd0;
        end
      end
      avba_pkg::S_A_BOUND: begin
        off <= 6'd0;
        if (over) res_status <= avba_pkg::ST_NOSPACE;
      end
      avba_pkg::S_A_CHK: begin
        if (rdata.kind != avba_pkg::KIND_UNUSED) begin
          base <= sum;
          off  <= 6'd0;
        end else begin
          off <= last ? 6'd0 : off_inc;
        end
      end
      avba_pkg::S_A_WR: begin
        off <= off_inc;
        if (last) begin
          res_status <= avba_pkg::ST_OK;
          res_base   <= base[7:0];
        end
      end
      avba_pkg::S_R_BOUND: begin
        off        <= 6'd0;
        have_next  <= 32'(sum) < VECTORS;
        res_status <= avba_pkg::ST_BASE;
      end
      avba_pkg::S_R_CHK: begin
        if (off == n) begin
          off <= 6'd0;
        end else begin
          if (!kind_match) res_status <= avba_pkg::ST_KIND;
          base_bad <= bb;
          off      <= (last && !have_next) ? 6'd0 : off_inc;
        end
      end
      avba_pkg::S_R_WR: begin
        off <= off_inc;
        if (last) res_status <= avba_pkg::ST_OK;
      end
      avba_pkg::S_M_CHK: begin
        if (rdata.kind != avba_pkg::KIND_MSI && rdata.kind != avba_pkg::KIND_MSIX) begin
          res_status <= avba_pkg::ST_KIND;
        end else if (rdata.base > base) begin
          res_status <= avba_pkg::ST_BASE;
        end else begin
          res_status <= avba_pkg::ST_OK;
          res_base   <= rdata.base[7:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == avba_pkg::S_DONE && out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == avba_pkg::S_DONE && out_load) begin
      out_status <= res_status;
      out_base   <= res_base;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.base_vector = out_base;

endmodule

// ===== hw/rtl/avba_table.sv =====
// per-cpu vector table memory with its clearing pass after reset
// depends on avba_pkg
module avba_table #(
  parameter int VECTORS       = avba_pkg::DEF_VECTORS,
  parameter int CPUS          = avba_pkg::DEF_CPUS,
  parameter int LEGACY_LINES  = avba_pkg::DEF_LEGACY_LINES,
  localparam int VEC_W        = $clog2(VECTORS),
  localparam int CPU_W        = (CPUS > 1) ? $clog2(CPUS) : 1,
  localparam int ADDR_W       = CPU_W + VEC_W,
  localparam int DEPTH        = 1 << ADDR_W
) (
  input  logic                   clk,
  input  logic                   rst,
  output logic                   busy,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  avba_pkg::entry_t       wdata,
  input  logic [ADDR_W-1:0]      raddr,
  output avba_pkg::entry_t       rdata
);

  avba_pkg::entry_t  mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // entry contents after reset
  function automatic avba_pkg::entry_t reset_entry(input logic [CPU_W-1:0] c,
                                                   input logic [VEC_W-1:0] v);
    avba_pkg::entry_t e;
    e.kind = avba_pkg::KIND_UNUSED;
    e.base = avba_pkg::BASE_NONE;
    if (32'(v) < LEGACY_LINES) begin
      if (c != '0) begin
        e.kind = avba_pkg::KIND_RESERVED;
      end else if (32'(v) == avba_pkg::CASCADE_LINE) begin
        e.kind = avba_pkg::KIND_RESERVED;
      end else begin
        e.kind = avba_pkg::KIND_LEGACY;
      end
    end
    if (32'(v) == avba_pkg::SYSCALL_SLOT && 32'(v) < VECTORS) begin
      e.kind = avba_pkg::KIND_SYSCALL;
    end
    return e;
  endfunction

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (&clr_addr) begin
        busy <= 1'b0;
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= reset_entry(clr_addr[ADDR_W-1:VEC_W], clr_addr[VEC_W-1:0]);
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/avba_checker.sv =====
// port-level checks of the allocator top, attached by bind
// depends on assert_macros.svh and aligned_vector_block_allocator_top
`include "assert_macros.svh"

module avba_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_status,
  input logic [7:0] rsp_base
);

  // clearing pass keeps requests out right after reset
  `AVBA_ASSERT_NR(a_rst_blocks_req, clk, (rst |=> !req_ready))

  // one request at a time: ready drops after an accepted beat
  `AVBA_ASSERT(a_busy_after_accept, clk, rst, ((req_valid && req_ready) |=> !req_ready))

  // a result never rises in the cycle after its request beat
  `AVBA_ASSERT(a_no_instant_result, clk, rst,
    ((req_valid && req_ready) |=> !$rose(rsp_valid)))

  // a stalled result beat holds
  `AVBA_ASSERT(a_rsp_hold, clk, rst,
    ((rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_base))))

endmodule

bind aligned_vector_block_allocator_top avba_checker u_avba_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_base   (rsp.base_vector)
);

// ===== tb/sv/vector_table_checker.sv =====
// checker for the vector block allocator: watches request, response and config beats,
// predicts each response from its own copy of the vector tables and compares them
// depends on avba_pkg and avba_if
module vector_table_checker
  import avba_pkg::*;
#(
  parameter int VECTORS      = DEF_VECTORS,
  parameter int CPUS         = DEF_CPUS,
  parameter int LEGACY_LINES = DEF_LEGACY_LINES
) (
  input  logic clk,
  input  logic rst,
  avba_req_if  req_ch,
  avba_rsp_if  rsp_ch,
  avba_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    status_t    status;
    logic [7:0] base;
  } answer_t;

  // per cpu table copy: kind and owning block base (bit 8 set means none)
  kind_t      kind_tab  [CPUS][VECTORS];
  logic [8:0] owner_tab [CPUS][VECTORS];
  logic [7:0] scan_from;
  answer_t    expected_answers [$];

  task automatic report(string what);
    $display("vector table mismatch: %s", what);
    errors++;
  endtask

  function automatic bit size_ok(int n);
    return n >= 1 && n <= MAX_BLOCK && (n & (n - 1)) == 0;
  endfunction

  // first aligned run of n unused vectors from the scan start
  function automatic status_t take_block(int c, kind_t k, int n, output logic [7:0] at);
    bit free;
    at = '0;
    for (int i = int'(scan_from); i + n <= VECTORS; i += n) begin
      free = 1'b1;
      for (int j = 0; j < n; j++)
        if (kind_tab[c][i + j] != KIND_UNUSED) free = 1'b0;
      if (free) begin
        for (int j = 0; j < n; j++) begin
          kind_tab[c][i + j]  = k;
          owner_tab[c][i + j] = 9'(i);
        end
        at = 8'(i);
        return ST_OK;
      end
    end
    return ST_NOSPACE;
  endfunction

  // whole block must match in kind and base, and not run on past n
  function automatic status_t free_block(int c, kind_t k, int b, int n);
    if (b + n > VECTORS || (b & (n - 1)) != 0) return ST_BASE;
    for (int j = 0; j < n; j++)
      if (kind_tab[c][b + j] != k) return ST_KIND;
    for (int j = 0; j < n; j++)
      if (owner_tab[c][b + j] != 9'(b)) return ST_BASE;
    if (b + n < VECTORS && kind_tab[c][b + n] == k && owner_tab[c][b + n] == 9'(b))
      return ST_BASE;
    for (int j = 0; j < n; j++) begin
      kind_tab[c][b + j]  = KIND_UNUSED;
      owner_tab[c][b + j] = BASE_NONE;
    end
    return ST_OK;
  endfunction

  function automatic answer_t serve_request(logic [2:0] f, logic [3:0] cpu, logic [7:0] v,
                                            logic [5:0] cnt);
    answer_t    a;
    logic [7:0] at;
    int         c;
    a.status = ST_BADREQ;
    at = '0;
    c = int'(cpu);
    if (c < CPUS) begin
      case (f)
        FN_ALLOC_MSI:  if (size_ok(cnt)) a.status = take_block(c, KIND_MSI, cnt, at);
        FN_ALLOC_MSIX: a.status = take_block(c, KIND_MSIX, 1, at);
        FN_REL_MSI:    if (size_ok(cnt)) a.status = free_block(c, KIND_MSI, v, cnt);
        FN_REL_MSIX:   a.status = free_block(c, KIND_MSIX, v, 1);
        FN_MAP: begin
          if (v < VECTORS) begin
            if (kind_tab[c][v] != KIND_MSI && kind_tab[c][v] != KIND_MSIX) begin
              a.status = ST_KIND;
            end else if (owner_tab[c][v] == BASE_NONE || owner_tab[c][v] > v) begin
              a.status = ST_BASE;
            end else begin
              a.status = ST_OK;
              at = owner_tab[c][v][7:0];
            end
          end
        end
        default: ;
      endcase
    end
    a.base = (a.status == ST_OK) ? at : 8'd0;
    return a;
  endfunction

  // one pass per clock edge: config, then response compare, then new request
  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      scan_from = '0;
      expected_answers.delete();
      for (int c = 0; c < CPUS; c++) begin
        for (int v = 0; v < VECTORS; v++) begin
          owner_tab[c][v] = BASE_NONE;
          if (v == SYSCALL_SLOT)
            kind_tab[c][v] = KIND_SYSCALL;
          else if (v < LEGACY_LINES)
            kind_tab[c][v] = (c != 0 || v == CASCADE_LINE) ? KIND_RESERVED : KIND_LEGACY;
          else
            kind_tab[c][v] = KIND_UNUSED;
        end
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) scan_from = cfg_ch.data & START_MASK;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_answers.size() == 0) begin
          report($sformatf("response beat with nothing expected, status %0d base %0d",
                           rsp_ch.status, rsp_ch.base_vector));
        end else begin
          want = expected_answers.pop_front();
          if (rsp_ch.status != want.status)
            report($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
          if (rsp_ch.base_vector != want.base)
            report($sformatf("base_vector %0d, expected %0d", rsp_ch.base_vector, want.base));
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_answers.push_back(serve_request(req_ch.func, req_ch.cpu, req_ch.vector,
                                                 req_ch.count));
    end
    pending = expected_answers.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// top of the vector block allocator testbench: clock, reset, request stimulus,
// response stalls, config writes and the verdict
// depends on avba_pkg, avba_if, the allocator top and vector_table_checker
module tb;
  import avba_pkg::*;

  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 75;

  // a block known to be allocated, learned from response beats
  typedef struct {
    logic [3:0] cpu;
    logic [7:0] base;
    int         n;
    bit         msix;
  } block_t;

  typedef struct {
    logic [2:0] func;
    logic [3:0] cpu;
    int         n;
  } sent_t;

  logic   clk = 1'b0;
  logic   rst;
  int     errors;
  int     pending;
  int     sent;
  int     idle_cycles;
  bit     calm;
  block_t live_blocks [$];
  sent_t  in_flight [$];

  avba_req_if req_ch ();
  avba_rsp_if rsp_ch ();
  avba_cfg_if cfg_ch ();

  aligned_vector_block_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  vector_table_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .req_ch  (req_ch),
    .rsp_ch  (rsp_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // one request beat, with an occasional idle burst in front
  task automatic send_req(logic [2:0] f, logic [3:0] c, logic [7:0] v, logic [5:0] n);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.func   <= f;
    req_ch.cpu    <= c;
    req_ch.vector <= v;
    req_ch.count  <= n;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    in_flight.push_back('{f, c, (f == FN_ALLOC_MSIX) ? 1 : int'(n)});
    sent++;
  endtask

  task automatic write_start(logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering, wait for every response, then let the block settle
  task automatic finish_phase();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // mostly alloc/release/map of live blocks, a few broken releases and noise
  task automatic random_item();
    int         r;
    int         k;
    block_t     b;
    logic [3:0] c;
    r = $urandom_range(0, 99);
    c = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    if (r < 35) begin
      if ($urandom_range(0, 3) != 0)
        send_req(FN_ALLOC_MSI, c, 8'($urandom), 6'(1 << $urandom_range(0, 5)));
      else
        send_req(FN_ALLOC_MSIX, c, 8'($urandom), 6'($urandom));
    end else if (r < 70 && live_blocks.size() != 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[k];
      live_blocks.delete(k);
      case ($urandom_range(0, 9))
        // broken releases leave the block allocated
        0: begin
          send_req(b.msix ? FN_REL_MSI : FN_REL_MSIX, b.cpu, b.base, 6'(b.n));
          live_blocks.push_back(b);
        end
        1: begin
          send_req(FN_REL_MSI, b.cpu, b.base, 6'(b.n * 2));
          live_blocks.push_back(b);
        end
        2: begin
          send_req(FN_REL_MSI, b.cpu, b.base, 6'(b.n / 2));
          live_blocks.push_back(b);
        end
        3: begin
          send_req(b.msix ? FN_REL_MSIX : FN_REL_MSI, b.cpu, b.base + 8'd1, 6'(b.n));
          live_blocks.push_back(b);
        end
        default: begin
          if (b.msix) send_req(FN_REL_MSIX, b.cpu, b.base, 6'($urandom));
          else send_req(FN_REL_MSI, b.cpu, b.base, 6'(b.n));
        end
      endcase
    end else if (r < 85 && live_blocks.size() != 0) begin
      b = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      send_req(FN_MAP, b.cpu, 8'(b.base + $urandom_range(0, b.n - 1)), 6'($urandom));
    end else begin
      send_req(3'($urandom), 4'($urandom), 8'($urandom), 6'($urandom));
    end
  endtask

  // learn allocated blocks from response beats to shape later releases
  always @(posedge clk) begin : track_blocks
    sent_t s;
    if (!rst && rsp_ch.valid && rsp_ch.ready && in_flight.size() != 0) begin
      s = in_flight.pop_front();
      if (rsp_ch.status == ST_OK && (s.func == FN_ALLOC_MSI || s.func == FN_ALLOC_MSIX))
        live_blocks.push_back('{s.cpu, rsp_ch.base_vector, s.n, s.func == FN_ALLOC_MSIX});
    end
  end

  // response side: short random stalls and one long hold-off
  initial begin : rsp_sink
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[aligned_vector_block_allocator_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] starts [5];
    starts        = '{8'h3F, 8'hFF, 8'hA0, 8'h40, 8'h00};
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.func   <= FN_ALLOC_MSI;
    req_ch.cpu    <= '0;
    req_ch.vector <= '0;
    req_ch.count  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_start(8'h00);

    // directed: sizes, kinds, misaligned and overlong releases, unknown funcs
    send_req(FN_ALLOC_MSI, 4'd0, 8'd0, 6'd32);
    send_req(FN_ALLOC_MSI, 4'd0, 8'd0, 6'd0);
    send_req(FN_ALLOC_MSI, 4'd0, 8'd0, 6'd3);
    send_req(FN_ALLOC_MSI, 4'd0, 8'd0, 6'd63);
    send_req(FN_ALLOC_MSIX, 4'd1, 8'd255, 6'd0);
    send_req(FN_MAP, 4'd0, 8'd63, 6'd0);
    send_req(FN_MAP, 4'd1, 8'd16, 6'd0);
    send_req(FN_MAP, 4'd0, 8'd0, 6'd0);
    send_req(FN_REL_MSI, 4'd0, 8'd32, 6'd16);
    send_req(FN_REL_MSI, 4'd0, 8'd40, 6'd8);
    send_req(FN_REL_MSI, 4'd0, 8'd240, 6'd32);
    send_req(FN_REL_MSIX, 4'd0, 8'd32, 6'd1);
    send_req(FN_REL_MSI, 4'd0, 8'd32, 6'd32);
    send_req(FN_REL_MSI, 4'd0, 8'd32, 6'd32);
    send_req(FN_REL_MSIX, 4'd1, 8'd16, 6'd63);
    for (int f = FN_MAP + 1; f < 8; f++) send_req(3'(f), 4'd15, 8'd0, 6'd1);
    send_req(FN_ALLOC_MSI, 4'd15, 8'd0, 6'd1);
    finish_phase();

    // scan from the top block: fill it, run out of space, free it
    write_start(START_MASK);
    send_req(FN_ALLOC_MSI, 4'd3, 8'd0, 6'd32);
    send_req(FN_ALLOC_MSI, 4'd3, 8'd0, 6'd32);
    send_req(FN_ALLOC_MSIX, 4'd3, 8'd0, 6'd1);
    send_req(FN_MAP, 4'd3, 8'd255, 6'd0);
    send_req(FN_REL_MSI, 4'd3, 8'd224, 6'd32);

    foreach (starts[p]) begin
      finish_phase();
      write_start(starts[p]);
      calm = (p == 4);
      repeat (PHASE_ITEMS) random_item();
    end
    finish_phase();

    if (errors == 0) $display("[aligned_vector_block_allocator_top] OK");
    else $display("[aligned_vector_block_allocator_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/avba_pkg.sv
hw/rtl/avba_if.sv
hw/rtl/avba_table.sv
hw/rtl/aligned_vector_block_allocator_top.sv
hw/rtl/avba_checker.sv
tb/sv/vector_table_checker.sv
tb/sv/tb.sv
